// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the checker file ssm_chk.sv
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion on an explicit clock and active-low reset
`define ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");

// concurrent assertion on the block clock and reset
`define ASSERT_PORT(lbl, prop) \
  `ASSERT_CLK(lbl, clk_i, rst_ni, prop)

`endif

// ===== hw/rtl/ssm_pkg.sv =====
// package for the sorted sequence merge unit: sizes, codes and the
// command and status structs between controller and datapath
// no dependencies
package ssm_pkg;

  localparam int LIST_DEPTH = 32;
  localparam int WORD_W     = 32;
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
  localparam int ADDR_W     = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

  typedef enum logic [1:0] {
    CMD_LOAD_FIRST  = 2'd0,
    CMD_LOAD_SECOND = 2'd1,
    CMD_MERGE       = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_ITEM  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_MERGE = 2'b10
  } state_e;

  typedef struct packed {
    logic load_first;
    logic load_second;
    logic full_first;
    logic full_second;
    logic empty;
    logic start;
    logic step;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic first_full;
    logic second_full;
    logic both_empty;
    logic walk_last;
  } dp_sts_t;

endpackage

// ===== hw/rtl/ssm_ram.sv =====
// generic single write port ram with one registered read port
// no dependencies
module ssm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/ssm_ctrl.sv =====
// controller of the sorted sequence merge unit: input handshake,
// command decode and the merge walk state machine
// depends on ssm_pkg
module ssm_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [1:0]       cmd_i,
  input  ssm_pkg::dp_sts_t sts_i,
  output ssm_pkg::dp_cmd_t cmd_o
);

  ssm_pkg::state_e state_q, state_d;
  logic accept;

  assign in_stall_o = !((state_q == ssm_pkg::S_IDLE) && sts_i.out_free);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      ssm_pkg::S_IDLE: begin
        if (accept) begin
          unique case (cmd_i)
            ssm_pkg::CMD_LOAD_FIRST: begin
              cmd_o.full_first = sts_i.first_full;
              cmd_o.load_first = !sts_i.first_full;
            end
            ssm_pkg::CMD_LOAD_SECOND: begin
              cmd_o.full_second = sts_i.second_full;
              cmd_o.load_second = !sts_i.second_full;
            end
            ssm_pkg::CMD_MERGE: begin
              cmd_o.empty = sts_i.both_empty;
              cmd_o.start = !sts_i.both_empty;
              if (!sts_i.both_empty) begin
                state_d = ssm_pkg::S_MERGE;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ssm_pkg::S_MERGE: begin
        cmd_o.step = sts_i.out_free;
        if (sts_i.out_free && sts_i.walk_last) begin
          state_d = ssm_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = ssm_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ssm_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hw/rtl/ssm_datapath.sv =====
// datapath of the sorted sequence merge unit: list rams, counts,
// walk pointers, head compare and the output register
// depends on ssm_pkg and ssm_ram
module ssm_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  ssm_pkg::dp_cmd_t                  cmd_i,
  output ssm_pkg::dp_sts_t                  sts_o,
  input  logic signed [ssm_pkg::WORD_W-1:0] value_i,
  input  logic                              out_stall_i,
  output logic                              out_valid_o,
  output logic signed [ssm_pkg::WORD_W-1:0] item_value_o,
  output logic                              from_second_o,
  output logic [1:0]                        status_o,
  output logic                              last_item_o
);

  localparam int CW = ssm_pkg::CNT_W;
  localparam int AW = ssm_pkg::ADDR_W;
  localparam int DW = ssm_pkg::WORD_W;

  logic [CW-1:0] cnt1_q, cnt1_d, cnt2_q, cnt2_d;
  logic [CW-1:0] i_q, i_d, j_q, j_d;
  logic [DW-1:0] rd1, rd2;
  logic          rem1, rem2, take_first, walk_last, out_free, load_out;

  logic          out_valid_q, out_valid_d;
  logic [DW-1:0] value_q, value_d;
  logic          second_q, second_d;
  logic [1:0]    status_q, status_d;
  logic          last_q, last_d;

  ssm_ram #(.WIDTH(DW), .DEPTH(ssm_pkg::LIST_DEPTH)) u_first_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load_first),
    .waddr_i (cnt1_q[AW-1:0]),
    .wdata_i (value_i),
    .raddr_i (i_d[AW-1:0]),
    .rdata_o (rd1)
  );

  ssm_ram #(.WIDTH(DW), .DEPTH(ssm_pkg::LIST_DEPTH)) u_second_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load_second),
    .waddr_i (cnt2_q[AW-1:0]),
    .wdata_i (value_i),
    .raddr_i (j_d[AW-1:0]),
    .rdata_o (rd2)
  );

  // ram read data always belongs to the current pointers
  assign rem1       = i_q < cnt1_q;
  assign rem2       = j_q < cnt2_q;
  assign take_first = !rem2 || (rem1 && ($signed(rd1) <= $signed(rd2)));

  always_comb begin
    cnt1_d = cmd_i.load_first  ? cnt1_q + CW'(1) : cnt1_q;
    cnt2_d = cmd_i.load_second ? cnt2_q + CW'(1) : cnt2_q;
    i_d    = i_q;
    j_d    = j_q;
    if (cmd_i.start) begin
      i_d = '0;
      j_d = '0;
    end else if (cmd_i.step) begin
      if (take_first) begin
        i_d = i_q + CW'(1);
      end else begin
        j_d = j_q + CW'(1);
      end
    end
  end

  assign walk_last = (i_d >= cnt1_q) && (j_d >= cnt2_q);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign load_out  = cmd_i.step || cmd_i.full_first || cmd_i.full_second || cmd_i.empty;

  always_comb begin
    value_d  = '0;
    second_d = cmd_i.full_second;
    status_d = ssm_pkg::STAT_ITEM;
    last_d   = 1'b1;
    if (cmd_i.step) begin
      value_d  = take_first ? rd1 : rd2;
      second_d = !take_first;
      last_d   = walk_last;
    end else if (cmd_i.empty) begin
      status_d = ssm_pkg::STAT_EMPTY;
    end else begin
      status_d = ssm_pkg::STAT_FULL;
    end
    out_valid_d = load_out || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt1_q      <= '0;
      cnt2_q      <= '0;
      i_q         <= '0;
      j_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt1_q      <= cnt1_d;
      cnt2_q      <= cnt2_d;
      i_q         <= i_d;
      j_q         <= j_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      value_q  <= value_d;
      second_q <= second_d;
      status_q <= status_d;
      last_q   <= last_d;
    end
  end

  assign sts_o.out_free    = out_free;
  assign sts_o.first_full  = cnt1_q >= CW'(ssm_pkg::LIST_DEPTH);
  assign sts_o.second_full = cnt2_q >= CW'(ssm_pkg::LIST_DEPTH);
  assign sts_o.both_empty  = (cnt1_q == '0) && (cnt2_q == '0);
  assign sts_o.walk_last   = walk_last;

  assign out_valid_o   = out_valid_q;
  assign item_value_o  = value_q;
  assign from_second_o = second_q;
  assign status_o      = status_q;
  assign last_item_o   = last_q;

endmodule

// ===== hw/rtl/sorted_sequence_merge_unit.sv =====
// Sorted sequence merge unit: keeps two lists of up to 32 signed 32-bit
// values and on a merge word emits both in ascending order, first list
// first on a tie. After a load word the next word can be accepted in
// the following cycle if the output is free; a load into a full list
// gives one overflow result and an empty merge one empty-status result.
// A merge emits one stored value per cycle while the output is free,
// since each list ram has a single registered read port walked by its
// own pointer; no word is accepted until the last merged value has
// entered the output register. Output stall freezes the walk.
// depends on ssm_pkg, ssm_ctrl and ssm_datapath
module sorted_sequence_merge_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [1:0]                        cmd_i,
  input  logic signed [ssm_pkg::WORD_W-1:0] value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [ssm_pkg::WORD_W-1:0] item_value_o,
  output logic                              from_second_o,
  output logic [1:0]                        status_o,
  output logic                              last_item_o
);

  ssm_pkg::dp_cmd_t dp_cmd;
  ssm_pkg::dp_sts_t dp_sts;

  ssm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_i      (cmd_i),
    .sts_i      (dp_sts),
    .cmd_o      (dp_cmd)
  );

  ssm_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (dp_cmd),
    .sts_o         (dp_sts),
    .value_i       (value_i),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .item_value_o  (item_value_o),
    .from_second_o (from_second_o),
    .status_o      (status_o),
    .last_item_o   (last_item_o)
  );

endmodule

// ===== hw/rtl/ssm_chk.sv =====
// port-level checker for the sorted sequence merge unit, bound to the top
// depends on ssm_pkg and assert_macros.svh
`include "assert_macros.svh"

module ssm_chk (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_stall_o,
  input logic [1:0]                        cmd_i,
  input logic signed [ssm_pkg::WORD_W-1:0] value_i,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic signed [ssm_pkg::WORD_W-1:0] item_value_o,
  input logic                              from_second_o,
  input logic [1:0]                        status_o,
  input logic                              last_item_o
);

  logic mid_merge;

  assign mid_merge = out_valid_o && (status_o == ssm_pkg::STAT_ITEM) && !last_item_o;

  `ASSERT_PORT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(item_value_o) && $stable(status_o) && $stable(last_item_o))
  `ASSERT_PORT(a_status_single, out_valid_o && (status_o != ssm_pkg::STAT_ITEM) |-> (item_value_o == '0) && last_item_o)
  `ASSERT_PORT(a_empty_first, out_valid_o && (status_o == ssm_pkg::STAT_EMPTY) |-> !from_second_o)
  `ASSERT_PORT(a_merge_blocks_in, mid_merge |-> in_stall_o)
  `ASSERT_PORT(a_merge_streams, mid_merge && !out_stall_i |=> out_valid_o && (status_o == ssm_pkg::STAT_ITEM))

endmodule

bind sorted_sequence_merge_unit ssm_chk u_ssm_chk (.*);

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// testbench for the sorted sequence merge unit: load, merge and ignored words
// checked against a two-list model kept in the bench
// depends on ssm_pkg and sorted_sequence_merge_unit
module tb_top;
  import ssm_pkg::*;

  localparam logic [1:0] CMD_IGNORED = 2'd3;
  localparam logic signed [WORD_W-1:0] VALUE_MIN = {1'b1, {(WORD_W-1){1'b0}}};
  localparam logic signed [WORD_W-1:0] VALUE_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam int RANDOM_WORDS   = 430;
  localparam int HOLD_CYCLES    = 250;
  localparam int HOLD_AT_FIRST  = 30;
  localparam int HOLD_AT_SECOND = 300;
  localparam int IDLE_LIMIT     = 4000;
  localparam int SETTLE_CYCLES  = 80;
  localparam int REPORT_LIMIT   = 10;

  typedef struct packed {
    logic signed [WORD_W-1:0] value;
    logic                     from_second;
    status_e                  status;
    logic                     last;
  } result_t;

  typedef struct {
    logic [1:0]               op;
    logic signed [WORD_W-1:0] value;
    bit                       drain_first;
  } word_t;

  typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_ALTERNATE} rx_mode_e;

  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     in_valid_i  = 1'b0;
  logic                     in_stall_o;
  logic [1:0]               cmd_i       = '0;
  logic signed [WORD_W-1:0] value_i     = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic signed [WORD_W-1:0] item_value_o;
  logic                     from_second_o;
  logic [1:0]               status_o;
  logic                     last_item_o;

  logic signed [WORD_W-1:0] first_vals  [LIST_DEPTH];
  logic signed [WORD_W-1:0] second_vals [LIST_DEPTH];
  int first_len  = 0;
  int second_len = 0;

  result_t results_due[$];
  word_t   pending_words[$];

  int words_total;
  int words_taken     = 0;
  int results_awaited = 0;
  int error_count     = 0;
  int loads_seen      = 0;
  int merges_seen     = 0;
  int ignored_seen    = 0;
  int values_seen     = 0;
  int full_seen       = 0;
  int empty_seen      = 0;
  int gap_left        = 0;
  int burst_left      = 0;
  int hold_left       = 0;
  int holds_done      = 0;
  int mode_left       = 0;
  int idle_cycles     = 0;
  rx_mode_e rx_mode   = RX_FREE;

  sorted_sequence_merge_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .cmd_i         (cmd_i),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .item_value_o  (item_value_o),
    .from_second_o (from_second_o),
    .status_o      (status_o),
    .last_item_o   (last_item_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string what, input result_t want, input result_t got);
    error_count++;
    if (error_count <= REPORT_LIMIT) begin
      $display("%0t %s: expected %0d/%0b/%0d/%0b got %0d/%0b/%0d/%0b (value/second/status/last)",
               $time, what, $signed(want.value), want.from_second, want.status, want.last,
               $signed(got.value), got.from_second, got.status, got.last);
    end
  endtask

  // results caused by one word on the pair of lists
  task automatic step_list_pair(input logic [1:0] op, input logic signed [WORD_W-1:0] val);
    result_t r;
    int i;
    int j;
    logic take_first;
    r = '0;
    r.last = 1'b1;
    if (op == CMD_LOAD_FIRST || op == CMD_LOAD_SECOND) begin
      if (op == CMD_LOAD_FIRST && first_len < LIST_DEPTH) begin
        first_vals[first_len] = val;
        first_len++;
      end else if (op == CMD_LOAD_SECOND && second_len < LIST_DEPTH) begin
        second_vals[second_len] = val;
        second_len++;
      end else begin
        r.from_second = (op == CMD_LOAD_SECOND);
        r.status = STAT_FULL;
        results_due.push_back(r);
      end
    end else if (op == CMD_MERGE) begin
      if (first_len == 0 && second_len == 0) begin
        r.status = STAT_EMPTY;
        results_due.push_back(r);
      end else begin
        i = 0;
        j = 0;
        while (i < first_len || j < second_len) begin
          // first list wins a tie
          take_first = (j >= second_len) || (i < first_len && first_vals[i] <= second_vals[j]);
          if (take_first) begin
            r.value = first_vals[i];
            r.from_second = 1'b0;
            i++;
          end else begin
            r.value = second_vals[j];
            r.from_second = 1'b1;
            j++;
          end
          r.status = STAT_ITEM;
          r.last = (i >= first_len && j >= second_len);
          results_due.push_back(r);
        end
      end
    end
  endtask

  function automatic logic signed [WORD_W-1:0] sorted_next(
    input logic signed [WORD_W-1:0] tail,
    input logic signed [WORD_W-1:0] other
  );
    longint base;
    longint cand;
    base = tail;
    if ($urandom_range(0, 4) == 0 && other > tail) base = other;
    case ($urandom_range(0, 2))
      0: cand = base;
      1: cand = base + longint'($urandom_range(1, 16));
      default: cand = base + longint'($urandom_range(1, 1 << 24));
    endcase
    if (cand > VALUE_MAX) cand = VALUE_MAX;
    return cand[WORD_W-1:0];
  endfunction

  task automatic queue_word(input logic [1:0] op, input logic signed [WORD_W-1:0] val,
                            input bit drain);
    word_t w;
    w.op = op;
    w.value = val;
    w.drain_first = drain;
    pending_words.push_back(w);
  endtask

  always @(posedge clk_i) begin : driver
    word_t w;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!(in_valid_i && in_stall_o)) begin
      if (gap_left != 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (pending_words.size() == 0) begin
        in_valid_i <= 1'b0;
      end else if (pending_words[0].drain_first && (in_valid_i || results_awaited != 0)) begin
        in_valid_i <= 1'b0;
      end else begin
        w = pending_words.pop_front();
        cmd_i <= w.op;
        value_i <= w.value;
        in_valid_i <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left--;
        end
      end
    end
  end

  always @(posedge clk_i) begin : receiver
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (holds_done < 2 &&
                 words_taken >= ((holds_done == 0) ? HOLD_AT_FIRST : HOLD_AT_SECOND)) begin
      holds_done++;
      hold_left = HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 150);
      end else begin
        mode_left--;
      end
      case (rx_mode)
        RX_FREE:  out_stall_i <= 1'b0;
        RX_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
        RX_HEAVY: out_stall_i <= ($urandom_range(0, 9) < 7);
        default:  out_stall_i <= !out_stall_i;
      endcase
    end
  end

  always @(posedge clk_i) begin : monitor
    result_t got;
    result_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got.value = item_value_o;
        got.from_second = from_second_o;
        got.status = status_e'(status_o);
        got.last = last_item_o;
        case (got.status)
          STAT_FULL:  full_seen++;
          STAT_EMPTY: empty_seen++;
          default:    values_seen++;
        endcase
        if (results_due.size() == 0) begin
          report_mismatch("result with none due", '0, got);
        end else begin
          want = results_due.pop_front();
          if (got.value !== want.value || got.from_second !== want.from_second ||
              got.status !== want.status || got.last !== want.last) begin
            report_mismatch("field mismatch", want, got);
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        words_taken <= words_taken + 1;
        case (cmd_i)
          CMD_LOAD_FIRST, CMD_LOAD_SECOND: loads_seen++;
          CMD_MERGE:                       merges_seen++;
          default:                         ignored_seen++;
        endcase
        step_list_pair(cmd_i, value_i);
      end
      results_awaited <= results_due.size();
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles", idle_cycles);
        $display("RESULT: ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int counted;
    int bias;
    int pick;
    bit drain;
    logic [1:0] op;
    logic signed [WORD_W-1:0] v;
    logic signed [WORD_W-1:0] tail_first;
    logic signed [WORD_W-1:0] tail_second;

    // directed: empty merge, ignored code, one list empty, tie, unsorted list
    queue_word(CMD_MERGE, 32'sh1234_5678, 1'b0);
    queue_word(CMD_IGNORED, -32'sd1, 1'b0);
    queue_word(CMD_LOAD_SECOND, VALUE_MIN, 1'b0);
    queue_word(CMD_MERGE, '0, 1'b0);
    queue_word(CMD_LOAD_FIRST, VALUE_MIN, 1'b1);
    queue_word(CMD_MERGE, -32'sd1, 1'b0);
    queue_word(CMD_LOAD_SECOND, -32'sd100, 1'b0);
    queue_word(CMD_LOAD_FIRST, -32'sd100, 1'b0);
    queue_word(CMD_LOAD_FIRST, -32'sd3, 1'b0);
    queue_word(CMD_LOAD_SECOND, 32'sd0, 1'b0);
    queue_word(CMD_LOAD_SECOND, 32'sd0, 1'b0);
    queue_word(CMD_MERGE, VALUE_MAX, 1'b0);
    queue_word(CMD_LOAD_SECOND, VALUE_MAX, 1'b0);
    queue_word(CMD_LOAD_SECOND, 32'sd5, 1'b0);
    queue_word(CMD_MERGE, VALUE_MIN, 1'b1);
    queue_word(CMD_IGNORED, '0, 1'b0);
    queue_word(CMD_MERGE, '0, 1'b0);
    tail_first = -32'sd3;
    tail_second = 32'sd5;

    // random: mostly ascending appends, some unsorted noise and ignored codes
    counted = 0;
    bias = 50;
    while (counted < RANDOM_WORDS) begin
      if (counted % 20 == 0) bias = $urandom_range(10, 90);
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        queue_word(CMD_IGNORED, $urandom, 1'b0);
      end else begin
        counted++;
        drain = ($urandom_range(0, 39) == 0);
        if (pick < 22) begin
          queue_word(CMD_MERGE, $urandom, drain);
        end else begin
          op = ($urandom_range(0, 99) < bias) ? CMD_LOAD_SECOND : CMD_LOAD_FIRST;
          if (pick >= 88) begin
            v = $urandom;
          end else if (op == CMD_LOAD_FIRST) begin
            v = sorted_next(tail_first, tail_second);
            tail_first = v;
          end else begin
            v = sorted_next(tail_second, tail_first);
            tail_second = v;
          end
          queue_word(op, v, drain);
        end
      end
    end
    words_total = pending_words.size();

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (words_taken != words_total || results_awaited != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    while (results_due.size() != 0) begin
      report_mismatch("result never came", results_due.pop_front(), '0);
    end

    $display("run covered %0d words: %0d loads, %0d merges, %0d ignored codes",
             words_taken, loads_seen, merges_seen, ignored_seen);
    $display("checked %0d merged values, %0d overflows, %0d empty merges, %0d mismatches",
             values_seen, full_seen, empty_seen, error_count);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
